@@ src/ssel_pkg.sv @@
// ---------------------------------------------------------------------------
// ssel_pkg: shared constants, types and tables of the stick sector selector
// Holds the CORDIC step table, unit widths and the default parameter values.
// ---------------------------------------------------------------------------
package ssel_pkg;

  localparam int MAX_SLOTS_DEF  = 16;
  localparam int ANGLE_BITS_DEF = 16;

  // CORDIC: sixteen vectoring steps, 32-bit turn accumulator
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int CW           = 20;   // a/b datapath, covers gain and the half-turn flip
  localparam int ZW           = 32;

  // serial magnitude accumulator: |x|^2 + |y|^2 - dz^2, signed
  localparam int MAG_W = 34;

  typedef struct packed {
    logic done;    // accumulation finished, under is valid
    logic under;   // magnitude squared below dead zone squared
  } mag_stat_t;

  // arctan(2^-i) in 32-bit turns
  function automatic logic [ZW-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [ZW-1:0] t;
    unique case (i)
      4'd0:  t = 32'h2000_0000;
      4'd1:  t = 32'h12E4_051E;
      4'd2:  t = 32'h09FB_385B;
      4'd3:  t = 32'h0511_11D4;
      4'd4:  t = 32'h028B_0D43;
      4'd5:  t = 32'h0145_D7E1;
      4'd6:  t = 32'h00A2_F61E;
      4'd7:  t = 32'h0051_7C55;
      4'd8:  t = 32'h0028_BE53;
      4'd9:  t = 32'h0014_5F2F;
      4'd10: t = 32'h000A_2F98;
      4'd11: t = 32'h0005_17CC;
      4'd12: t = 32'h0002_8BE6;
      4'd13: t = 32'h0001_45F3;
      4'd14: t = 32'h0000_A2F9;
      4'd15: t = 32'h0000_517D;
    endcase
    return t;
  endfunction

endpackage

@@ src/stick_sector_selector.sv @@
// One item at a time: the next input is taken only in S_IDLE, once the previous
//   result has been loaded into the output register; S_POST waits while that
//   register is still full.
// The 16-step CORDIC and the serial slot-count multiply set how long an item takes.
// Reset (rst, synchronous): registers take their documented reset values,
//   nothing is hovered, the output register is empty.
// ---------------------------------------------------------------------------
// stick_sector_selector: radial sector selector for a 2-D analog stick
// Maps each stick sample to one of N angular sectors, keeps the hovered
// sector, flags hover changes and confirms enabled sectors on a press.
// ---------------------------------------------------------------------------
module stick_sector_selector #(
  parameter int MAX_SLOTS  = ssel_pkg::MAX_SLOTS_DEF,
  parameter int ANGLE_BITS = ssel_pkg::ANGLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // stick_x[15:0], stick_y[31:16], confirm_press[32]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // hovered_index[3:0], hovered_none[4],
                                      // hover_changed[5], confirmed[6]
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ssel_pkg::*;

  localparam int SW = $clog2(MAX_SLOTS + 1);
  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  typedef enum logic [1:0] {
    REG_SLOT_COUNT,
    REG_DEAD_ZONE,
    REG_START_ANGLE,
    REG_SLOT_ENABLE
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,    // wait for an input transaction
    S_FRONT,   // CORDIC and dead zone test run side by side
    S_QUANT,   // serial multiply into a sector
    S_POST     // update hover state and load the output register
  } state_t;

  state_t state;

  // configuration registers
  logic [4:0]  slot_count;
  logic [14:0] dead_zone;
  logic [15:0] start_angle;
  logic [15:0] slot_enable_mask;

  // hover state
  logic [IW-1:0] hover_slot;
  logic          hover_empty;

  logic               press;
  logic               in_fire;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  logic signed [15:0] stick_x, stick_y;

  logic [SW-1:0]         n;
  logic                  cordic_done;
  logic [ANGLE_BITS-1:0] angle;
  mag_stat_t             mag_stat;
  logic                  quant_start;
  logic                  quant_done;
  logic [IW-1:0]         sect;
  logic [ANGLE_BITS-1:0] start_scaled;
  logic [ANGLE_BITS-1:0] rel;
  logic [16+ANGLE_BITS-1:0] start_wide;

  logic          out_free;
  logic          none_next;
  logic [IW-1:0] slot_next;
  logic          changed;
  logic          conf;

  assign stick_x = s_axis_tdata[15:0];
  assign stick_y = s_axis_tdata[31:16];

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // ------------------------------------------------------------------
  // register port: writes land on the access phase, reads are direct
  // ------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      REG_SLOT_COUNT:  prdata = 32'(slot_count);
      REG_DEAD_ZONE:   prdata = 32'(dead_zone);
      REG_START_ANGLE: prdata = 32'(start_angle);
      REG_SLOT_ENABLE: prdata = 32'(slot_enable_mask);
    endcase
  end

  // saturate the slot count to what the sector logic can index
  assign n = (32'(slot_count) > MAX_SLOTS) ? SW'(MAX_SLOTS) : SW'(slot_count);

  // rescale the 16-bit start angle to ANGLE_BITS by a plain shift
  assign start_wide   = {start_angle, {ANGLE_BITS{1'b0}}};
  assign start_scaled = start_wide[16+ANGLE_BITS-1:16];
  assign rel          = angle - start_scaled;

  // ------------------------------------------------------------------
  // datapath units
  // ------------------------------------------------------------------
  ssel_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (in_fire),
    .x     (stick_x),
    .y     (stick_y),
    .done  (cordic_done),
    .angle (angle)
  );

  ssel_mag u_mag (
    .clk       (clk),
    .rst       (rst),
    .start     (in_fire),
    .x         (stick_x),
    .y         (stick_y),
    .dead_zone (dead_zone),
    .stat      (mag_stat)
  );

  assign quant_start = (state == S_FRONT) && cordic_done && mag_stat.done;

  ssel_quant #(
    .ANGLE_BITS (ANGLE_BITS),
    .MAX_SLOTS  (MAX_SLOTS)
  ) u_quant (
    .clk   (clk),
    .rst   (rst),
    .start (quant_start),
    .rel   (rel),
    .n     (n),
    .done  (quant_done),
    .sect  (sect)
  );

  // ------------------------------------------------------------------
  // hover update: a sample inside the dead zone, or no slots, hovers none
  // ------------------------------------------------------------------
  always_comb begin
    none_next = (n == '0) || mag_stat.under;
    slot_next = none_next ? '0 : sect;
    if (none_next) begin
      changed = !hover_empty;
    end else begin
      changed = hover_empty || (hover_slot != sect);
    end
    // press confirms only an enabled slot inside the mask's reach
    conf = press && !none_next && (SW'(slot_next) < n) && (32'(slot_next) < 16) &&
           slot_enable_mask[4'(slot_next)];
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      m_axis_tvalid    <= 1'b0;
      hover_slot       <= '0;
      hover_empty      <= 1'b1;
      slot_count       <= '0;
      dead_zone        <= '0;
      start_angle      <= '0;
      slot_enable_mask <= 16'hFFFF;
    end else begin
      // drop the result once the sink takes it, unless a new one takes its place
      if (m_axis_tvalid && m_axis_tready && (state != S_POST)) m_axis_tvalid <= 1'b0;

      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_SLOT_COUNT: begin
            slot_count  <= pwdata[4:0];
            // a new slot layout forgets the hover silently
            hover_slot  <= '0;
            hover_empty <= 1'b1;
          end
          REG_DEAD_ZONE:   dead_zone        <= pwdata[14:0];
          REG_START_ANGLE: start_angle      <= pwdata[15:0];
          REG_SLOT_ENABLE: slot_enable_mask <= pwdata[15:0];
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            press <= s_axis_tdata[32];
            state <= S_FRONT;
          end
        end
        S_FRONT: begin
          if (quant_start) state <= S_QUANT;
        end
        S_QUANT: begin
          if (quant_done) state <= S_POST;
        end
        S_POST: begin
          // hold until the output register is free
          if (out_free) begin
            hover_slot    <= slot_next;
            hover_empty   <= none_next;
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {1'b0, conf, changed, none_next, 4'(slot_next)};
            state         <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ src/ssel_cordic.sv @@
// ---------------------------------------------------------------------------
// ssel_cordic: iterative vectoring CORDIC
// One micro-rotation per cycle; gives atan2(x, y) in ANGLE_BITS-bit turns.
// ---------------------------------------------------------------------------
module ssel_cordic #(
  parameter int ANGLE_BITS = ssel_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [15:0]           x,
  input  logic signed [15:0]           y,
  output logic                         done,
  output logic        [ANGLE_BITS-1:0] angle
);
  import ssel_pkg::*;

  localparam logic [ZW-1:0] RND = ZW'(1) << (31 - ANGLE_BITS);

  logic signed [CW-1:0] a, b;
  logic signed [CW-1:0] da, db;
  logic        [ZW-1:0] z;
  logic        [ZW-1:0] z_rnd;
  logic        [STEP_W-1:0] step;
  logic                 busy;
  logic                 zero;
  logic                 b_pos;

  assign da    = b >>> step;
  assign db    = a >>> step;
  assign b_pos = !b[CW-1] && (b != '0);
  assign z_rnd = z + RND;
  assign angle = zero ? '0 : z_rnd[ZW-1 -: ANGLE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
      zero <= (x == '0) && (y == '0);
      // fold the lower half plane up by a half turn
      if (y[15]) begin
        a <= -CW'(y);
        b <= -CW'(x);
        z <= ZW'(1) << (ZW - 1);
      end else begin
        a <= CW'(y);
        b <= CW'(x);
        z <= '0;
      end
    end else if (busy) begin
      if (b_pos) begin
        a <= a + da;
        b <= b - db;
        z <= z + atan_turn(step);
      end else begin
        a <= a - da;
        b <= b + db;
        z <= z - atan_turn(step);
      end
      step <= step + 1'b1;
      if (step == STEP_W'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

@@ src/ssel_mag.sv @@
// ---------------------------------------------------------------------------
// ssel_mag: bit-serial dead zone test
// Accumulates x^2 + y^2 - dz^2 one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module ssel_mag (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [15:0]      x,
  input  logic signed [15:0]      y,
  input  logic        [14:0]      dead_zone,
  output ssel_pkg::mag_stat_t     stat
);
  import ssel_pkg::*;

  logic        [31:0]       mx, my, md;
  logic        [15:0]       bx, by, bd;
  logic signed [MAG_W-1:0]  acc;
  logic signed [MAG_W-1:0]  term;
  logic        [STEP_W-1:0] cnt;
  logic                     busy;
  logic                     done;
  logic        [15:0]       ax, ay;

  // magnitudes fit 16 unsigned bits, -32768 included
  assign ax = x[15] ? 16'(-x) : 16'(x);
  assign ay = y[15] ? 16'(-y) : 16'(y);

  always_comb begin
    term = '0;
    if (bx[0]) term = term + MAG_W'(mx);
    if (by[0]) term = term + MAG_W'(my);
    if (bd[0]) term = term - MAG_W'(md);
  end

  assign stat.done  = done;
  assign stat.under = acc[MAG_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      acc  <= '0;
      mx   <= 32'(ax);
      my   <= 32'(ay);
      md   <= 32'(dead_zone);
      bx   <= ax;
      by   <= ay;
      bd   <= 16'(dead_zone);
    end else if (busy) begin
      acc <= acc + term;
      mx  <= mx << 1;
      my  <= my << 1;
      md  <= md << 1;
      bx  <= bx >> 1;
      by  <= by >> 1;
      bd  <= bd >> 1;
      cnt <= cnt + 1'b1;
      if (cnt == STEP_W'(15)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

@@ src/ssel_quant.sv @@
// ---------------------------------------------------------------------------
// ssel_quant: serial sector quantizer
// Shift-add multiply of the relative angle by the slot count, then round.
// ---------------------------------------------------------------------------
module ssel_quant #(
  parameter int ANGLE_BITS = ssel_pkg::ANGLE_BITS_DEF,
  parameter int MAX_SLOTS  = ssel_pkg::MAX_SLOTS_DEF,
  localparam int SW = $clog2(MAX_SLOTS + 1),
  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [ANGLE_BITS-1:0] rel,
  input  logic [SW-1:0]         n,
  output logic                  done,
  output logic [IW-1:0]         sect
);

  localparam int PW    = ANGLE_BITS + SW;
  localparam int CNT_W = $clog2(SW + 1);
  localparam logic [PW-1:0] HALF = PW'(1) << (ANGLE_BITS - 1);

  logic [PW-1:0]    prod, mcand, qsum;
  logic [SW-1:0]    mplier, nreg, q;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  assign qsum = prod + HALF;
  assign q    = qsum[PW-1:ANGLE_BITS];
  // q never exceeds n, so the wrap is one compare
  assign sect = (q == nreg) ? '0 : IW'(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy   <= 1'b1;
      done   <= 1'b0;
      cnt    <= '0;
      prod   <= '0;
      mcand  <= PW'(rel);
      mplier <= n;
      nreg   <= n;
    end else if (busy) begin
      if (mplier[0]) prod <= prod + mcand;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      cnt    <= cnt + 1'b1;
      if (cnt == CNT_W'(SW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

@@ src/ssel_checker.sv @@
// ---------------------------------------------------------------------------
// ssel_checker: port-level checks of the stick sector selector
// Watches the result stream and the input handshake over time.
// ---------------------------------------------------------------------------
module ssel_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // no hover shows index zero
  a_none_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3:0] == 4'd0)
    else $error("index set while nothing hovered");

  // a confirm needs a hovered sector
  a_conf_hover: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[6] |-> !m_axis_tdata[4])
    else $error("confirm with nothing hovered");

  // one item at a time: an input transaction closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

endmodule

bind stick_sector_selector ssel_checker u_ssel_checker (.*);

@@ bench/stick_sector_selector_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stick_sector_selector_tb: self-checking bench for the stick sector selector
// Drives stick samples through the input stream and programs the four
// registers over the register port. A bit-accurate model of the vectoring
// CORDIC, the dead-zone test, the sector quantizer and the hover/confirm state
// predicts the results that no directed row types in. A short directed table
// comes first, then random samples under changing settings and back-pressure.
// ---------------------------------------------------------------------------
module stick_sector_selector_tb;

  // Register indexes; the byte address is four times the index
  typedef enum logic [1:0] {
    REG_SLOT_COUNT,
    REG_DEAD_ZONE,
    REG_START_ANGLE,
    REG_SLOT_MASK
  } cfg_reg_t;

  // One result, laid out as in m_axis_tdata[6:0]
  typedef struct packed {
    logic       conf;
    logic       chg;
    logic       none;
    logic [3:0] idx;
  } hover_res_t;

  // One row of the directed part: optional register write, then a sample
  typedef struct packed {
    logic        wr;
    cfg_reg_t    sel;
    logic [31:0] wval;
    logic [15:0] x;
    logic [15:0] y;
    logic        press;
    logic        chk;      // expectation typed in below, else from the predictor
    logic [3:0]  e_idx;
    logic        e_none;
    logic        e_chg;
    logic        e_conf;
  } vec_t;

  localparam int SLOTS_MAX     = ssel_pkg::MAX_SLOTS_DEF;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 30;   // longer than one item's pass through the block
  localparam int SEG_ITEMS     = 94;
  localparam int REPORT_MAX    = 10;

  // arctan(2^-i) in 32-bit turns
  localparam logic [31:0] ATAN_TURNS [16] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517D
  };

  // Directed samples: cardinal directions, corners, zero vector, dead-zone
  // edges, enable mask, start angle, slot count saturation and the hover
  // clear that a slot count write causes.
  localparam vec_t DIRECTED [24] = '{
    // nothing selectable after reset, press ignored
    '{1'b0, REG_SLOT_COUNT, 32'd0, 16'h7FFF, 16'h0000, 1'b1, 1'b1, 4'd0, 1'b1, 1'b0, 1'b0},
    // four slots: up lands in sector 0 and is confirmed
    '{1'b1, REG_SLOT_COUNT, 32'd4, 16'h0000, 16'h7FFF, 1'b1, 1'b1, 4'd0, 1'b0, 1'b1, 1'b1},
    '{1'b0, REG_SLOT_COUNT, 32'd0, 16'h7FFF, 16'h0000, 1'b0, 1'b1, 4'd1, 1'b0, 1'b1, 1'b0},
    // same sector again: no change flag
    '{1'b0, REG_SLOT_COUNT, 32'd0, 16'h7FFF, 16'h0000, 1'b1, 1'b1, 4'd1, 1'b0, 1'b0, 1'b1},
    '{1'b0, REG_SLOT_COUNT, 32'd0, 16'h0000, 16'h8000, 1'b1, 1'b1, 4'd2, 1'b0, 1'b1, 1'b1},
    '{1'b0, REG_SLOT_COUNT, 32'd0, 16'h8000, 16'h0000, 1'b0, 1'b1, 4'd3, 1'b0, 1'b1, 1'b0},
    '{1'b0, REG_SLOT_COUNT, 32'd0, 16'h8000, 16'h8000, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_SLOT_COUNT, 32'd0, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0},
    // zero vector with no dead zone
    '{1'b0, REG_SLOT_COUNT, 32'd0, 16'h0000, 16'h0000, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0},
    // dead zone 1000: just inside, exactly on the radius, tiny vector
    '{1'b1, REG_DEAD_ZONE, 32'd1000, 16'd600, 16'd799, 1'b1, 1'b1, 4'd0, 1'b1, 1'b1, 1'b0},
    '{1'b0, REG_SLOT_COUNT, 32'd0, 16'd600, 16'd800, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_SLOT_COUNT, 32'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 4'd0, 1'b1, 1'b1, 1'b0},
    // largest dead zone: on the radius, then just inside
    '{1'b1, REG_DEAD_ZONE, 32'd32767, 16'h7FFF, 16'h0000, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_SLOT_COUNT, 32'd0, 16'd23169, 16'd23169, 1'b1, 1'b1, 4'd0, 1'b1, 1'b1, 1'b0},
    // enable mask cleared, then only slot 1 enabled
    '{1'b1, REG_SLOT_MASK, 32'h0000, 16'h7FFF, 16'h0000, 1'b1, 1'b1, 4'd1, 1'b0, 1'b1, 1'b0},
    '{1'b1, REG_SLOT_MASK, 32'h0002, 16'h7FFF, 16'h0000, 1'b1, 1'b1, 4'd1, 1'b0, 1'b0, 1'b1},
    // start angle extremes
    '{1'b1, REG_START_ANGLE, 32'hFFFF, 16'h0000, 16'h7FFF, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0},
    '{1'b1, REG_START_ANGLE, 32'h8000, 16'h0000, 16'h8000, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0},
    // slot count above the maximum saturates
    '{1'b1, REG_SLOT_COUNT, 32'd31, 16'h8000, 16'h0000, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0},
    // one slot: always sector 0, hover was cleared, bit 0 disabled
    '{1'b1, REG_SLOT_COUNT, 32'd1, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 4'd0, 1'b0, 1'b1, 1'b0},
    '{1'b1, REG_DEAD_ZONE, 32'd0, 16'h0000, 16'h0000, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0, 1'b0},
    '{1'b1, REG_SLOT_MASK, 32'hFFFF, 16'h8000, 16'h8000, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0, 1'b1},
    '{1'b1, REG_SLOT_COUNT, 32'd16, 16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0},
    // no slots right after a clear: none without a change flag
    '{1'b1, REG_SLOT_COUNT, 32'd0, 16'd5, 16'd5, 1'b1, 1'b1, 4'd0, 1'b1, 1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // stick_x[15:0], stick_y[31:16], confirm_press[32]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // hovered_index[3:0], hovered_none[4],
                                    // hover_changed[5], confirmed[6]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the registers and hover state
  logic [4:0]  cfg_slots = '0;
  logic [14:0] cfg_dead  = '0;
  logic [15:0] cfg_start = '0;
  logic [15:0] cfg_mask  = 16'hFFFF;
  logic [3:0]  hov_slot  = '0;
  logic        hov_empty = 1'b1;

  hover_res_t expected_hover_q [$];
  hover_res_t seen_res;
  hover_res_t want_res;
  int         errors = 0;
  int         stall_cycles = 0;
  int         src_idle_pct = 0;
  int         rx_idle_pct = 0;

  stick_sector_selector DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk = ~clk;

  // Work out the result of one sample and advance the hover state.
  function automatic hover_res_t predict_hover(logic signed [15:0] x,
                                               logic signed [15:0] y,
                                               logic press);
    hover_res_t  r;
    longint      sx, sy, a, b, da, db, mag2, dz2;
    longint unsigned q;
    logic [31:0] z;
    logic [15:0] ang, rel;
    int unsigned n, sect;
    logic        none;
    int          i;
    sx = x;
    sy = y;
    n = (cfg_slots > SLOTS_MAX) ? SLOTS_MAX : cfg_slots;
    mag2 = sx * sx + sy * sy;
    dz2 = longint'(cfg_dead) * longint'(cfg_dead);
    none = 1'b1;
    sect = 0;
    r = '0;
    if (n != 0 && mag2 >= dz2) begin
      ang = '0;
      if (sx != 0 || sy != 0) begin
        // vectoring CORDIC on (a = y, b = x), flipping the lower half plane first
        a = sy;
        b = sx;
        z = '0;
        if (a < 0) begin
          a = -a;
          b = -b;
          z = 32'h8000_0000;
        end
        for (i = 0; i < 16; i++) begin
          da = b >>> i;
          db = a >>> i;
          if (b > 0) begin
            a = a + da;
            b = b - db;
            z = z + ATAN_TURNS[i];
          end else begin
            a = a - da;
            b = b + db;
            z = z - ATAN_TURNS[i];
          end
        end
        z = z + 32'h0000_8000;
        ang = z[31:16];
      end
      rel = ang - cfg_start;
      q = (longint'(rel) * n + 32768) >> 16;
      sect = 32'(q % n);
      none = 1'b0;
    end
    if (none) begin
      r.chg = !hov_empty;
      hov_empty = 1'b1;
      hov_slot = '0;
    end else begin
      r.chg = hov_empty || (hov_slot != sect[3:0]);
      hov_empty = 1'b0;
      hov_slot = sect[3:0];
    end
    r.conf = press && !hov_empty && (hov_slot < n) && cfg_mask[hov_slot];
    r.idx = hov_slot;
    r.none = hov_empty;
    return r;
  endfunction

  function automatic logic [15:0] pick_edge();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'hFFFF;
      2:       return 16'h0000;
      3:       return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  task automatic flag_result(string what, hover_res_t want, hover_res_t got);
    errors++;
    if (errors <= REPORT_MAX)
      $display("%0t %s: expected idx=%0d none=%b chg=%b conf=%b, %s",
               $time, what, want.idx, want.none, want.chg, want.conf,
               $sformatf("got idx=%0d none=%b chg=%b conf=%b",
                         got.idx, got.none, got.chg, got.conf));
  endtask

  // Register write: setup cycle, access cycle, then the bus goes idle.
  // Start and end on a falling edge.
  task automatic apb_write(cfg_reg_t sel, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // mirror the write into the predictor
    case (sel)
      REG_SLOT_COUNT: begin
        cfg_slots = val[4:0];
        hov_slot  = '0;
        hov_empty = 1'b1;
      end
      REG_DEAD_ZONE:   cfg_dead  = val[14:0];
      REG_START_ANGLE: cfg_start = val[15:0];
      REG_SLOT_MASK:   cfg_mask  = val[15:0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Send one sample. Start and end on a falling edge; tvalid stays high on return
  // so that a following sample goes out back to back.
  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic press,
                             logic use_fixed, hover_res_t fixed_res);
    hover_res_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, press, y, x};
    do @(posedge clk); while (!s_axis_tready);
    // transaction taken: run the predictor to keep its state in step
    pred = predict_hover(x, y, press);
    expected_hover_q.push_back(use_fixed ? fixed_res : pred);
    @(negedge clk);
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_hover_q.size() != 0) @(negedge clk);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Check every result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_res = hover_res_t'(m_axis_tdata[6:0]);
      if (expected_hover_q.size() == 0) begin
        flag_result("unexpected result", '0, seen_res);
      end else begin
        want_res = expected_hover_q.pop_front();
        if (seen_res.idx !== want_res.idx || seen_res.none !== want_res.none ||
            seen_res.chg !== want_res.chg || seen_res.conf !== want_res.conf)
          flag_result("result mismatch", want_res, seen_res);
      end
    end
  end

  // Watchdog: count cycles without any transaction on any port.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    hover_res_t  fixed;
    logic [15:0] x, y, last_x, last_y;
    logic        press;
    int          k, phase, seg;
    last_x = '0;
    last_y = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: drain before each register write so the block is idle.
    src_idle_pct = 6;
    rx_idle_pct  = 55;
    for (k = 0; k < $size(DIRECTED); k++) begin
      if (DIRECTED[k].wr) begin
        drain();
        apb_write(DIRECTED[k].sel, DIRECTED[k].wval);
      end
      fixed = '{conf: DIRECTED[k].e_conf, chg: DIRECTED[k].e_chg,
                none: DIRECTED[k].e_none, idx: DIRECTED[k].e_idx};
      send_sample(DIRECTED[k].x, DIRECTED[k].y, DIRECTED[k].press,
                  DIRECTED[k].chk, fixed);
    end

    // Random part: three idling regimes, each split into segments with their
    // own register settings.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 6;  rx_idle_pct = 55; end
        1: begin src_idle_pct = 55; rx_idle_pct = 6;  end
        default: begin src_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (seg = 0; seg < 4; seg++) begin
        drain();
        // retune a random subset of the registers, extremes included
        if (seg == 0 || $urandom_range(1)) begin
          case ($urandom_range(7))
            0:       apb_write(REG_SLOT_COUNT, 32'd0);
            1:       apb_write(REG_SLOT_COUNT, 32'd31);
            2:       apb_write(REG_SLOT_COUNT, 32'd17);
            3:       apb_write(REG_SLOT_COUNT, 32'd16);
            default: apb_write(REG_SLOT_COUNT, $urandom_range(16, 1));
          endcase
        end
        if ($urandom_range(1)) begin
          case ($urandom_range(5))
            0:       apb_write(REG_DEAD_ZONE, 32'd0);
            1:       apb_write(REG_DEAD_ZONE, 32'd32767);
            2:       apb_write(REG_DEAD_ZONE, $urandom_range(32767));
            default: apb_write(REG_DEAD_ZONE, $urandom_range(3000));
          endcase
        end
        if ($urandom_range(1)) begin
          case ($urandom_range(4))
            0:       apb_write(REG_START_ANGLE, 32'h0000);
            1:       apb_write(REG_START_ANGLE, 32'hFFFF);
            default: apb_write(REG_START_ANGLE, $urandom_range(16'hFFFF));
          endcase
        end
        if ($urandom_range(1)) begin
          case ($urandom_range(4))
            0:       apb_write(REG_SLOT_MASK, 32'h0000);
            1:       apb_write(REG_SLOT_MASK, 32'hFFFF);
            default: apb_write(REG_SLOT_MASK, $urandom_range(16'hFFFF));
          endcase
        end
        for (k = 0; k < SEG_ITEMS; k++) begin
          // now and then let the pipeline run dry
          if ($urandom_range(49) == 0)
            drain();
          case ($urandom_range(9))
            5: begin
              x = pick_edge();
              y = pick_edge();
            end
            6: begin
              // small vectors around typical dead-zone radii
              x = 16'($urandom_range(4095)) - 16'd2048;
              y = 16'($urandom_range(4095)) - 16'd2048;
            end
            7, 8: begin
              // jitter around the last sample so the hover often holds
              x = {last_x[15:4], 4'($urandom)};
              y = {last_y[15:4], 4'($urandom)};
            end
            default: begin
              x = 16'($urandom);
              y = 16'($urandom);
            end
          endcase
          press = 1'($urandom_range(1));
          last_x = x;
          last_y = y;
          send_sample(x, y, press, 1'b0, '0);
        end
      end
    end

    // Wind down: let every result arrive, then watch for stray ones.
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    errors += expected_hover_q.size();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
